// ===== sv/attribute_video_cell_renderer_assert.svh =====
// Assertion macros for the checker of the cell renderer.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ATTRIBUTE_VIDEO_CELL_RENDERER_ASSERT_SVH
`define ATTRIBUTE_VIDEO_CELL_RENDERER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AVCR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("avcr check failed");

// The consequent must hold in the cycle after the antecedent.
`define AVCR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("avcr check failed");

`endif

// ===== sv/avcr_pkg.sv =====
`timescale 1ns / 1ps

package avcr_pkg;

  // Screen geometry.
  localparam int unsigned TopBorderLines = 24;
  localparam int unsigned ActiveLines    = 192;
  localparam int unsigned LeftCells      = 4;
  localparam int unsigned ActiveCells    = 32;

  // Display store layout.
  localparam int unsigned BitmapBytes = 6144;
  localparam int unsigned AttrBytes   = 768;
  localparam int unsigned StoreBytes  = BitmapBytes + AttrBytes;
  localparam int unsigned StoreAw     = $clog2(StoreBytes);
  localparam int unsigned BitmapAw    = $clog2(BitmapBytes);
  localparam int unsigned AttrAw      = $clog2(AttrBytes);

  // Register reset values.
  localparam logic [2:0] BorderReset = 3'd7;
  localparam logic [7:0] FlashReset  = 8'd19;

  // Register indexes on the configuration port.
  localparam logic [1:0] RegPowerOn = 2'd0;
  localparam logic [1:0] RegBorder  = 2'd1;
  localparam logic [1:0] RegFlash   = 2'd2;

  // Request from the renderer to the display store.
  typedef struct packed {
    logic                wr_en;
    logic [StoreAw-1:0]  wr_addr;
    logic [7:0]          wr_data;
    logic                rd_en;
    logic [BitmapAw-1:0] bm_addr;
    logic [AttrAw-1:0]   at_addr;
  } st_req_t;

endpackage

// ===== sv/avcr_store.sv =====
`timescale 1ns / 1ps

module avcr_store import avcr_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  st_req_t      req_i,
  output logic         ready_o,
  output logic [7:0]   bm_data_o,
  output logic [7:0]   at_data_o
);

  logic [7:0] bm_mem [BitmapBytes];
  logic [7:0] at_mem [AttrBytes];

  logic                clr_busy_q, clr_busy_d;
  logic [BitmapAw-1:0] clr_cnt_q, clr_cnt_d;
  logic                wr_bm, wr_at;

  // Both memories are swept together; the attribute memory is the shorter one.
  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_cnt_d  = clr_cnt_q;
    if (clr_busy_q) begin
      clr_cnt_d = clr_cnt_q + 1'b1;
      if (clr_cnt_q == BitmapAw'(BitmapBytes - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_cnt_q  <= clr_cnt_d;
    end
  end

  // Writes beyond the end of the store fall on neither memory.
  assign wr_bm = req_i.wr_en && (req_i.wr_addr < StoreAw'(BitmapBytes));
  assign wr_at = req_i.wr_en && (req_i.wr_addr >= StoreAw'(BitmapBytes))
                             && (req_i.wr_addr < StoreAw'(StoreBytes));

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      bm_mem[clr_cnt_q] <= '0;
    end else if (wr_bm) begin
      bm_mem[req_i.wr_addr[BitmapAw-1:0]] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      bm_data_o <= bm_mem[req_i.bm_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      if (clr_cnt_q < BitmapAw'(AttrBytes)) begin
        at_mem[clr_cnt_q[AttrAw-1:0]] <= '0;
      end
    end else if (wr_at) begin
      at_mem[req_i.wr_addr[AttrAw-1:0]] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      at_data_o <= at_mem[req_i.at_addr];
    end
  end

  assign ready_o = !clr_busy_q;

endmodule

// ===== sv/attribute_video_cell_renderer.sv =====
`timescale 1ns / 1ps

// Attribute video cell renderer. Once its display store has been cleared after
// reset (the bitmap and attribute memories are swept together, one byte a cycle),
// the block accepts one beat per clock cycle while the output side keeps up. A
// render beat passes through the synchronous read of the bitmap and attribute
// memories, which are read in parallel, and then the output register. Write beats
// and renders while power is off produce no result. The configuration registers
// sit on an APB port at byte addresses 0 (power), 4 (border colour) and 8 (flash
// period).
module attribute_video_cell_renderer import avcr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // From bit 0: address[12:0], write_data[20:13], scanline[28:21],
  // column[34:29], zero fill[39:35].
  input  logic [39:0] s_axis_tdata_i,
  // operation[0]: 0 writes a store byte, 1 renders a cell.
  input  logic        s_axis_tuser_i,
  // Output stream.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // pixel_indices[63:0], leftmost pixel in the top nibble.
  output logic [63:0] m_axis_tdata_o,
  // is_border[0].
  output logic        m_axis_tuser_o,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration registers.
  logic       power_q;
  logic [2:0] border_q;
  logic [7:0] flash_frames_q;
  logic       cfg_wr;

  // Frame and flash counters.
  logic [7:0] frame_q, frame_d;
  logic       flash_q, flash_d;

  // Input fields.
  logic [StoreAw-1:0] in_addr;
  logic [7:0]         in_wdata;
  logic [7:0]         in_line;
  logic [5:0]         in_col;

  // Pipeline control.
  logic    st_ready;
  logic    in_acc, acc_render, acc_write;
  logic    out_adv;
  logic    s1_valid_q, s1_valid_d;
  logic    s1_border_q;
  logic    s1_flash_q;
  logic    out_valid_q;
  logic [63:0] out_data_q, out_data_d;
  logic    out_border_q;

  // Cell addressing.
  logic       cell_border;
  logic [7:0] act_y;
  logic [4:0] act_x;
  logic [8:0] frame_next;
  logic [7:0] frame_limit;

  // Pixel decode.
  logic [7:0] bm_byte, at_byte;
  logic [3:0] ink, paper, fg, bg;

  st_req_t st_req;

  assign in_addr  = s_axis_tdata_i[12:0];
  assign in_wdata = s_axis_tdata_i[20:13];
  assign in_line  = s_axis_tdata_i[28:21];
  assign in_col   = s_axis_tdata_i[34:29];

  // ---------------------------------------------------------------------------
  // Configuration port. Writes complete in the access phase; reads are
  // returned from the same registers.
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      power_q        <= 1'b0;
      border_q       <= BorderReset;
      flash_frames_q <= FlashReset;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        RegPowerOn: power_q        <= pwdata[0];
        RegBorder:  border_q       <= pwdata[2:0];
        RegFlash:   flash_frames_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegPowerOn: prdata = {31'd0, power_q};
      RegBorder:  prdata = {29'd0, border_q};
      RegFlash:   prdata = {24'd0, flash_frames_q};
      default:    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Handshake. The stage holding the memory read data moves on whenever the
  // output register is empty or being drained, so a new beat is taken every
  // cycle while the downstream side keeps up.
  // ---------------------------------------------------------------------------
  assign out_adv         = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = st_ready && (!s1_valid_q || out_adv);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign acc_write       = in_acc && !s_axis_tuser_i;
  // A render while power is off is swallowed and does not count a frame.
  assign acc_render      = in_acc && s_axis_tuser_i && power_q;

  // ---------------------------------------------------------------------------
  // Cell classification and store addressing. Line 0 is always border, so the
  // flash phase only matters for later cells of the frame.
  // ---------------------------------------------------------------------------
  assign cell_border = (in_line < 8'(TopBorderLines))
                    || (in_line >= 8'(TopBorderLines + ActiveLines))
                    || (in_col < 6'(LeftCells))
                    || (in_col >= 6'(LeftCells + ActiveCells));
  assign act_y = in_line - 8'(TopBorderLines);
  assign act_x = 5'(in_col - 6'(LeftCells));

  always_comb begin
    st_req.wr_en   = acc_write;
    st_req.wr_addr = in_addr;
    st_req.wr_data = in_wdata;
    st_req.rd_en   = acc_render && !cell_border;
    // Bitmap rows are interleaved: third, then pixel line, then character row.
    st_req.bm_addr = {act_y[7:6], act_y[2:0], act_y[5:3], act_x};
    st_req.at_addr = {act_y[7:3], act_x};
  end

  avcr_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (st_req),
    .ready_o   (st_ready),
    .bm_data_o (bm_byte),
    .at_data_o (at_byte)
  );

  // ---------------------------------------------------------------------------
  // Frame counter. A period of zero behaves as a period of one.
  // ---------------------------------------------------------------------------
  assign frame_limit = (flash_frames_q == 8'd0) ? 8'd1 : flash_frames_q;
  assign frame_next  = {1'b0, frame_q} + 9'd1;

  always_comb begin
    frame_d = frame_q;
    flash_d = flash_q;
    if (acc_render && (in_line == 8'd0) && (in_col == 6'd0)) begin
      if (frame_next >= {1'b0, frame_limit}) begin
        frame_d = '0;
        flash_d = !flash_q;
      end else begin
        frame_d = frame_next[7:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= '0;
      flash_q <= 1'b0;
    end else begin
      frame_q <= frame_d;
      flash_q <= flash_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Read stage: the memories hold the fetched bytes; this stage carries the
  // matching control alongside them.
  // ---------------------------------------------------------------------------
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (acc_render) begin
      s1_valid_d = 1'b1;
    end else if (out_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_render) begin
      s1_border_q <= cell_border;
      s1_flash_q  <= flash_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Pixel decode. Bright sets the top bit of both indices, flash swaps them
  // while the flash phase is set, and every bitmap pixel covers two outputs.
  // ---------------------------------------------------------------------------
  assign ink   = {at_byte[6], at_byte[2:0]};
  assign paper = {at_byte[6], at_byte[5:3]};
  assign fg    = (at_byte[7] && s1_flash_q) ? paper : ink;
  assign bg    = (at_byte[7] && s1_flash_q) ? ink : paper;

  always_comb begin
    if (s1_border_q) begin
      out_data_d = {16{1'b0, border_q}};
    end else begin
      for (int i = 0; i < 8; i++) begin
        out_data_d[8*i +: 8] = bm_byte[i] ? {fg, fg} : {bg, bg};
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && s1_valid_q) begin
      out_data_q   <= out_data_d;
      out_border_q <= s1_border_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_border_q;

endmodule

// ===== sv/avcr_checker.sv =====
`timescale 1ns / 1ps

`include "attribute_video_cell_renderer_assert.svh"

module avcr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [63:0] m_axis_tdata_o,
  input logic        m_axis_tuser_o
);

  logic [31:0] hi_nib, lo_nib;

  // Upper and lower nibble of every byte of the result.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      hi_nib[4*i +: 4] = m_axis_tdata_o[8*i+4 +: 4];
      lo_nib[4*i +: 4] = m_axis_tdata_o[8*i +: 4];
    end
  end

  // A stalled result beat holds its contents.
  `AVCR_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i,
    m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))

  // A border beat is one colour from the lower half of the palette.
  `AVCR_ASSERT_NOW(a_border_flat, m_axis_tvalid_o && m_axis_tuser_o,
    (m_axis_tdata_o == {16{m_axis_tdata_o[3:0]}}) && !m_axis_tdata_o[3])

  // Every bitmap pixel is shown twice.
  `AVCR_ASSERT_NOW(a_pixel_double, m_axis_tvalid_o && !m_axis_tuser_o,
    hi_nib == lo_nib)

endmodule

bind attribute_video_cell_renderer avcr_checker u_avcr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

// ===== dv/attribute_video_cell_renderer_tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the attribute video cell renderer.
// Store writes and cell renders go in on the input stream. Every accepted beat
// is also applied to a behavioural model of the screen kept in this module.
// Each render that should give a result queues the expected cell. The output
// stream is compared with that queue field by field as results arrive.
module attribute_video_cell_renderer_tb;
  import avcr_pkg::*;

  // Values of the operation flag carried on s_axis_tuser_i.
  localparam logic OpWrite  = 1'b0;
  localparam logic OpRender = 1'b1;

  // A render result passes through the memory read and then the output register,
  // so DrainCycles is plenty to be sure that nothing is still in flight.
  localparam int DrainCycles   = 8;
  // The limit is well above both the time the store takes to clear after reset
  // and the long output hold-off of HoldCycles.
  localparam int WatchdogLimit = 20000;
  localparam int HoldCycles    = 300;

  typedef struct packed {
    logic        op;
    logic [12:0] addr;
    logic [7:0]  data;
    logic [7:0]  line;
    logic [5:0]  col;
  } cell_beat_t;

  typedef struct {
    logic [63:0] pixels;
    logic        border;
  } cell_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  // From bit 0: address[12:0], write_data[20:13], scanline[28:21],
  // column[34:29], zero fill[39:35].
  logic [39:0] s_axis_tdata_i;
  // operation[0].
  logic        s_axis_tuser_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  // pixel_indices[63:0].
  logic [63:0] m_axis_tdata_o;
  // is_border[0].
  logic        m_axis_tuser_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Behavioural copy of the screen: the store, the frame and flash counters
  // and the three registers.
  logic [7:0]   screen_bytes [StoreBytes];
  logic [7:0]   frame_count;
  logic         flash_on;
  logic         power_reg;
  logic [2:0]   border_reg;
  logic [7:0]   flash_period;
  cell_result_t cells_due [$];

  int mismatch_count = 0;
  int beats_accepted = 0;
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int hold_request   = 0;
  int hold_left      = 0;
  int quiet_cycles   = 0;

  attribute_video_cell_renderer u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Screen geometry helpers. The bitmap is interleaved: the top two bits of the
  // line pick the third of the screen, the low three bits the pixel row within
  // a character, and the middle three bits the character row.
  // ---------------------------------------------------------------------------
  function automatic logic [12:0] bitmap_addr(input logic [7:0] y, input logic [4:0] x);
    return {y[7:6], y[2:0], y[5:3], x};
  endfunction

  // One attribute byte covers an 8x8 character, 32 characters to a row.
  function automatic logic [12:0] attr_addr(input logic [7:0] y, input logic [4:0] x);
    return 13'(BitmapBytes) + 13'({y[7:3], x});
  endfunction

  function automatic cell_beat_t write_beat(input logic [12:0] addr, input logic [7:0] data);
    cell_beat_t b;
    b      = '0;
    b.op   = OpWrite;
    b.addr = addr;
    b.data = data;
    return b;
  endfunction

  function automatic cell_beat_t render_beat(input logic [7:0] line, input logic [5:0] col);
    cell_beat_t b;
    b      = '0;
    b.op   = OpRender;
    b.line = line;
    b.col  = col;
    return b;
  endfunction

  // ---------------------------------------------------------------------------
  // Screen model. Applies one accepted beat and queues the cell that the block
  // should return for it, if any.
  // ---------------------------------------------------------------------------
  task automatic paint_cell(input cell_beat_t b);
    cell_result_t res;
    logic [8:0]   next_count;
    logic [8:0]   limit;
    logic [7:0]   y;
    logic [4:0]   x;
    logic [7:0]   bits;
    logic [7:0]   attr;
    logic [3:0]   ink;
    logic [3:0]   paper;
    logic [3:0]   swap;
    logic [3:0]   colour;
    // Writes beyond the end of the store are dropped and never give a result.
    if (b.op == OpWrite) begin
      if (b.addr < StoreBytes) screen_bytes[b.addr] = b.data;
      return;
    end
    // With power off a render is swallowed whole, including the frame count.
    if (!power_reg) return;

    // The top-left border cell marks the start of a frame. A period of zero
    // behaves as one, so the flash phase then flips on every frame.
    if (b.line == 8'd0 && b.col == 6'd0) begin
      next_count = {1'b0, frame_count} + 9'd1;
      limit      = (flash_period == 8'd0) ? 9'd1 : {1'b0, flash_period};
      if (next_count >= limit) begin
        frame_count = 8'd0;
        flash_on    = ~flash_on;
      end else begin
        frame_count = next_count[7:0];
      end
    end

    // Columns from 40 up fall into the right border along with 36 to 39.
    if (b.line < TopBorderLines || b.line >= TopBorderLines + ActiveLines ||
        b.col < LeftCells || b.col >= LeftCells + ActiveCells) begin
      res.pixels = {16{{1'b0, border_reg}}};
      res.border = 1'b1;
    end else begin
      y     = 8'(b.line - TopBorderLines);
      x     = 5'(b.col - LeftCells);
      bits  = screen_bytes[bitmap_addr(y, x)];
      attr  = screen_bytes[attr_addr(y, x)];
      // Bright lifts both colours into the upper half of the palette.
      ink   = {attr[6], attr[2:0]};
      paper = {attr[6], attr[5:3]};
      if (attr[7] && flash_on) begin
        swap  = ink;
        ink   = paper;
        paper = swap;
      end
      // Each bitmap pixel becomes two output pixels, leftmost at the top.
      res.pixels = '0;
      for (int i = 7; i >= 0; i--) begin
        colour     = bits[i] ? ink : paper;
        res.pixels = {res.pixels[55:0], colour, colour};
      end
      res.border = 1'b0;
    end
    cells_due.push_back(res);
  endtask

  // ---------------------------------------------------------------------------
  // Input side. The valid line is left high after an accepted beat so that the
  // next beat can follow back to back; it is lowered only for an idle cycle or
  // when the stream goes quiet.
  // ---------------------------------------------------------------------------
  task automatic send_beat(input cell_beat_t b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {5'b0, b.col, b.line, b.data, b.addr};
    s_axis_tuser_i  <= b.op;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    paint_cell(b);
    beats_accepted++;
  endtask

  // Stops the input stream, waits for every queued cell and then lets the
  // pipeline run dry, so that a render swallowed by power off cannot be
  // overtaken by a register write.
  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    while (cells_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [1:0] reg_idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (reg_idx)
      RegPowerOn: power_reg    = value[0];
      RegBorder:  border_reg   = value[2:0];
      RegFlash:   flash_period = value[7:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(input logic power, input logic [2:0] border,
                           input logic [7:0] period);
    wait_idle();
    apb_write(RegPowerOn, 32'(power));
    apb_write(RegBorder, 32'(border));
    apb_write(RegFlash, 32'(period));
  endtask

  // One slice of random traffic. Most of it is a well-formed cell update:
  // bitmap and attribute bytes for one character cell followed by a render of
  // that cell. The rest is frame marks, random renders, loose writes and noise.
  task automatic send_random_group();
    int         pick;
    logic [7:0] y;
    logic [4:0] x;
    cell_beat_t b;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      b.op   = 1'($urandom_range(0, 1));
      b.addr = 13'($urandom_range(0, 8191));
      b.data = 8'($urandom);
      b.line = 8'($urandom);
      b.col  = 6'($urandom_range(0, 63));
      send_beat(b);
    end else if (pick < 18) begin
      send_beat(render_beat(8'd0, 6'd0));
    end else if (pick < 32) begin
      send_beat(render_beat(8'($urandom), 6'($urandom_range(0, 63))));
    end else if (pick < 42) begin
      send_beat(write_beat(13'($urandom_range(0, StoreBytes - 1)), 8'($urandom)));
    end else begin
      y = 8'($urandom_range(0, ActiveLines - 1));
      x = 5'($urandom);
      if ($urandom_range(0, 3) != 0) send_beat(write_beat(bitmap_addr(y, x), 8'($urandom)));
      if ($urandom_range(0, 3) != 0) send_beat(write_beat(attr_addr(y, x), 8'($urandom)));
      send_beat(render_beat(8'(y + TopBorderLines), 6'(x + LeftCells)));
    end
  endtask

  task automatic send_random_run(input int count);
    int start;
    start = beats_accepted;
    while (beats_accepted - start < count) send_random_group();
  endtask

  // ---------------------------------------------------------------------------
  // Output side: checking, random back-pressure and the long hold-off.
  // ---------------------------------------------------------------------------
  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("MISMATCH %s: got %h, expected %h", what, got, want);
    mismatch_count++;
  endtask

  task automatic check_cell();
    cell_result_t want;
    if (cells_due.size() == 0) begin
      flag_mismatch("result with nothing expected", m_axis_tdata_o, 64'd0);
      return;
    end
    want = cells_due.pop_front();
    if (m_axis_tdata_o !== want.pixels)
      flag_mismatch("pixel_indices", m_axis_tdata_o, want.pixels);
    if (m_axis_tuser_o !== want.border)
      flag_mismatch("is_border", 64'(m_axis_tuser_o), 64'(want.border));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) check_cell();
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // The watchdog only counts cycles in which no beat moves on either stream
  // and no register access completes.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (psel && penable)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Out of reset the power is off: renders, the frame mark among them, must
  // vanish without a result and without moving the frame counter.
  task automatic test_power_off();
    send_beat(render_beat(8'd24, 6'd4));
    send_beat(render_beat(8'd0, 6'd0));
    send_beat(render_beat(8'd100, 6'd20));
  endtask

  // Writes at both ends of the bitmap and the attribute area, plus writes past
  // the end of the store that must not land anywhere, then the two corner
  // cells that read those bytes back.
  task automatic test_store_extremes();
    configure(1'b1, 3'd2, 8'd19);
    send_beat(write_beat(13'd0, 8'h81));
    send_beat(write_beat(13'd6143, 8'hA5));
    send_beat(write_beat(13'd6144, 8'h47));
    send_beat(write_beat(13'd6911, 8'hD1));
    send_beat(write_beat(13'd6912, 8'h55));
    send_beat(write_beat(13'd8191, 8'hFF));
    send_beat(render_beat(8'd24, 6'd4));
    send_beat(render_beat(8'd215, 6'd35));
  endtask

  // Lines and columns just outside the active area, the last line and the
  // columns beyond the right border, all with border colour zero.
  task automatic test_border_cells();
    configure(1'b1, 3'd0, 8'd19);
    send_beat(render_beat(8'd23, 6'd10));
    send_beat(render_beat(8'd216, 6'd10));
    send_beat(render_beat(8'd255, 6'd63));
    send_beat(render_beat(8'd100, 6'd3));
    send_beat(render_beat(8'd100, 6'd36));
    send_beat(render_beat(8'd100, 6'd39));
    send_beat(render_beat(8'd100, 6'd40));
    send_beat(render_beat(8'd100, 6'd63));
  endtask

  // A flash period of zero flips the phase on every frame mark; the bottom
  // right cell carries a flashing bright attribute from the store test.
  task automatic test_flash_period();
    configure(1'b1, 3'd7, 8'd0);
    send_beat(render_beat(8'd0, 6'd0));
    send_beat(render_beat(8'd215, 6'd35));
    send_beat(render_beat(8'd0, 6'd0));
    send_beat(render_beat(8'd215, 6'd35));
  endtask

  // Random traffic against a slow sink, flashing on every frame.
  task automatic test_random_slow_sink();
    send_idle_pct = 29;
    recv_idle_pct = 62;
    configure(1'b1, 3'd5, 8'd1);
    send_random_run(230);
  endtask

  // Random traffic from a slow source, with a stretch in the middle where the
  // power is off and nothing should come out.
  task automatic test_random_slow_source();
    send_idle_pct = 62;
    recv_idle_pct = 29;
    configure(1'b1, 3'($urandom), 8'd2);
    send_random_run(100);
    configure(1'b0, 3'($urandom), 8'd2);
    send_random_run(30);
    configure(1'b1, 3'($urandom), 8'd2);
    send_random_run(100);
  endtask

  // Random traffic at full rate on both sides, longest flash period.
  task automatic test_random_full_rate();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    configure(1'b1, 3'd7, 8'd255);
    send_random_run(230);
  endtask

  // The sink holds off for a long stretch while renders keep coming, so the
  // pipeline fills up and the block has to stall its input.
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    configure(1'b1, 3'd4, 8'd3);
    hold_request = HoldCycles;
    for (int i = 0; i < 40; i++) begin
      if (i % 10 == 0) send_beat(render_beat(8'd0, 6'd0));
      else send_beat(render_beat(8'($urandom), 6'($urandom_range(0, 39))));
    end
  endtask

  initial begin
    // Every input is known from the start; reset is asserted once only.
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= OpWrite;
    m_axis_tready_i <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;

    // The model starts from the reset state of the block.
    for (int i = 0; i < StoreBytes; i++) screen_bytes[i] = 8'd0;
    frame_count  = 8'd0;
    flash_on     = 1'b0;
    power_reg    = 1'b0;
    border_reg   = BorderReset;
    flash_period = FlashReset;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The directed tests run under the same idling as the first random run.
    send_idle_pct = 29;
    recv_idle_pct = 62;
    test_power_off();
    test_store_extremes();
    test_border_cells();
    test_flash_period();
    test_random_slow_sink();
    test_random_slow_source();
    test_random_full_rate();
    test_output_backpressure();

    wait_idle();
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/avcr_pkg.sv
sv/avcr_store.sv
sv/attribute_video_cell_renderer.sv
sv/avcr_checker.sv
dv/attribute_video_cell_renderer_tb.sv
